>>> sv/gtbs_pkg.sv
// ----------------------------------------------------------------------------
// gtbs_pkg
// Shared types and constants of the glyph table search unit.
// ----------------------------------------------------------------------------
package gtbs_pkg;

  // Fixed field widths
  localparam int unsigned TotalW    = 11;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned FoundIdxW = 10;
  localparam int unsigned CmpW      = 33;
  localparam int unsigned CeilW     = 14;
  localparam int unsigned NeedW     = 30;

  // Result codes
  typedef enum logic [StatusW-1:0] {
    STAT_ACCEPTED  = 3'd0,
    STAT_COMPLETE  = 3'd1,
    STAT_FOUND     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_NOT_LOADED = 3'd4,
    STAT_ORDER_ERR = 3'd5,
    STAT_RANGE_ERR = 3'd6,
    STAT_OVERFLOW  = 3'd7
  } status_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_GLYPH_TOTAL  = 1'b0,
    REG_BITMAP_BYTES = 1'b1
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ORDER,
    S_RANGE,
    S_PROBE,
    S_COMPARE
  } state_e;

  // Flags of the shared compare unit
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_flags_t;

  // One table entry as stored
  typedef struct packed {
    logic [31:0]        codepoint;
    logic [15:0]        width;
    logic [15:0]        height;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [15:0]        advance;
    logic [31:0]        bitmap_start;
  } glyph_entry_t;

endpackage

>>> sv/gtbs_cmp_unit.sv
// ----------------------------------------------------------------------------
// gtbs_cmp_unit
// Shared unsigned magnitude compare used for order, range and search checks.
// ----------------------------------------------------------------------------
module gtbs_cmp_unit (
  input  logic [gtbs_pkg::CmpW-1:0] a_i,
  input  logic [gtbs_pkg::CmpW-1:0] b_i,
  output gtbs_pkg::cmp_flags_t      flags_o
);

  logic [gtbs_pkg::CmpW:0] diff;

  // Subtract once; borrow gives less-than
  assign diff       = {1'b0, a_i} - {1'b0, b_i};
  assign flags_o.lt = diff[gtbs_pkg::CmpW];
  assign flags_o.eq = (diff == '0);

endmodule

>>> sv/gtbs_glyph_mem.sv
// ----------------------------------------------------------------------------
// gtbs_glyph_mem
// Glyph entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gtbs_glyph_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  gtbs_pkg::glyph_entry_t wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output gtbs_pkg::glyph_entry_t rdata_o
);

  gtbs_pkg::glyph_entry_t mem_q [Depth];
  gtbs_pkg::glyph_entry_t rdata_q;

  // Write entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read entry
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/glyph_table_binary_search_unit.sv
// ----------------------------------------------------------------------------
// glyph_table_binary_search_unit
// Glyph table loader and codepoint lookup by binary search.
// ----------------------------------------------------------------------------
// Usage:
//   Configure glyph_total (index 0, restarts loading) and the bitmap area
//   size (index 1) through the cfg channel while the unit is idle; cfg_ready_o
//   is always high. Issue a request by raising start while busy is low:
//   operation_i = 0 loads the next entry, 1 looks up codepoint_i.
//   Each request gives exactly one result, shown for one cycle with
//   result_valid_o high; the receiver cannot stall it.
// Sequence of a request, from start to the result strobe:
//   load: decode, order check and size multiply, range check and write, strobe;
//   an order failure is strobed after the order check. A refused load or a
//   lookup before the table is valid is strobed after decode.
//   lookup: decode, then one probe after another until a hit or an empty
//   range, then the strobe; probes <= ceil(log2(glyph_total + 1)). Each probe
//   takes one entry-store read and one pass through the shared compare unit.
//   busy stays high until the result is registered; the next request may
//   start in the cycle the strobe is shown.
// Reset: clears the control registers, the load position and the table valid
//   and failure flags; entry store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module glyph_table_binary_search_unit #(
  parameter int unsigned MAX_GLYPHS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gtbs_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [gtbs_pkg::CfgDataW-1:0]       cfg_data_i,
  // Request channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation_i,
  input  logic [31:0]                         codepoint_i,
  input  logic [15:0]                         glyph_width_i,
  input  logic [15:0]                         glyph_height_i,
  input  logic signed [15:0]                  offset_x_i,
  input  logic signed [15:0]                  offset_y_i,
  input  logic [15:0]                         advance_width_i,
  input  logic [31:0]                         bitmap_start_i,
  // Result channel
  output logic                                result_valid_o,
  output logic [gtbs_pkg::StatusW-1:0]        status_o,
  output logic [gtbs_pkg::FoundIdxW-1:0]      found_index_o,
  output logic [15:0]                         found_width_o,
  output logic [15:0]                         found_height_o,
  output logic signed [15:0]                  found_offset_x_o,
  output logic signed [15:0]                  found_offset_y_o,
  output logic [15:0]                         found_advance_o,
  output logic [31:0]                         found_bitmap_start_o
);

  localparam int unsigned CntW  = $clog2(MAX_GLYPHS + 1);
  localparam int unsigned AddrW = $clog2(MAX_GLYPHS);
  localparam logic [31:0] MaxGlyphs32 = 32'(MAX_GLYPHS);

  // Sequencer state
  gtbs_pkg::state_e state_q, state_d;

  // Configuration and table status
  logic [CntW-1:0]  total_q, total_d;
  logic [31:0]      avail_q, avail_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [31:0]      prev_q, prev_d;
  logic             valid_q, valid_d;
  logic             failed_q, failed_d;

  // Captured request
  logic             op_q;
  gtbs_pkg::glyph_entry_t item_q;

  // Search and load working registers
  logic [CntW-1:0]  lo_q, lo_d;
  logic [CntW-1:0]  hi_q, hi_d;
  logic [AddrW-1:0] mid_q, mid_d;
  logic [gtbs_pkg::NeedW-1:0] need_q, need_d;

  // Result registers
  logic                          res_valid_q, res_valid_d;
  gtbs_pkg::status_e             res_status_q, res_status_d;
  logic [gtbs_pkg::FoundIdxW-1:0] res_index_q, res_index_d;
  gtbs_pkg::glyph_entry_t        res_entry_q, res_entry_d;

  // Shared compare unit and memory wiring
  logic [gtbs_pkg::CmpW-1:0] cmp_a, cmp_b;
  gtbs_pkg::cmp_flags_t      cmp_flags;
  logic                      mem_we, mem_re;
  gtbs_pkg::glyph_entry_t    mem_rdata;

  // Helper terms
  logic                      accept;
  logic                      cfg_write;
  logic                      refused;
  logic                      lo_lt_hi;
  logic [CntW:0]             mid_sum;
  logic [CntW-1:0]           mid_full;
  logic [CntW-1:0]           pos_inc;
  logic [gtbs_pkg::CeilW-1:0] ceil_bytes;
  logic [CntW-1:0]           total_req;

  assign busy        = (state_q != gtbs_pkg::S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  assign refused  = (total_q == '0) || valid_q || failed_q || (pos_q >= total_q);
  assign lo_lt_hi = (lo_q < hi_q);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_full = mid_sum[CntW:1];
  assign pos_inc  = pos_q + CntW'(1);
  assign ceil_bytes = gtbs_pkg::CeilW'(({1'b0, item_q.width} + 17'd7) >> 3);

  // Saturate the requested total to the table depth
  always_comb begin
    if ({21'b0, cfg_data_i[gtbs_pkg::TotalW-1:0]} > MaxGlyphs32) begin
      total_req = CntW'(MAX_GLYPHS);
    end else begin
      total_req = CntW'(cfg_data_i[gtbs_pkg::TotalW-1:0]);
    end
  end

  gtbs_cmp_unit u_cmp (
    .a_i     (cmp_a),
    .b_i     (cmp_b),
    .flags_o (cmp_flags)
  );

  gtbs_glyph_mem #(
    .Depth (MAX_GLYPHS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pos_q[AddrW-1:0]),
    .wdata_i (item_q),
    .re_i    (mem_re),
    .raddr_i (mid_full[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gtbs_pkg::S_IDLE: begin
        if (accept) state_d = gtbs_pkg::S_DECODE;
      end
      gtbs_pkg::S_DECODE: begin
        if (op_q) begin
          state_d = (valid_q && total_q != '0) ? gtbs_pkg::S_PROBE : gtbs_pkg::S_IDLE;
        end else begin
          state_d = refused ? gtbs_pkg::S_IDLE : gtbs_pkg::S_ORDER;
        end
      end
      gtbs_pkg::S_ORDER: begin
        state_d = (pos_q == '0 || cmp_flags.lt) ? gtbs_pkg::S_RANGE : gtbs_pkg::S_IDLE;
      end
      gtbs_pkg::S_RANGE: begin
        state_d = gtbs_pkg::S_IDLE;
      end
      gtbs_pkg::S_PROBE: begin
        state_d = lo_lt_hi ? gtbs_pkg::S_COMPARE : gtbs_pkg::S_IDLE;
      end
      gtbs_pkg::S_COMPARE: begin
        state_d = cmp_flags.eq ? gtbs_pkg::S_IDLE : gtbs_pkg::S_PROBE;
      end
      default: begin
        state_d = gtbs_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    cmp_a        = '0;
    cmp_b        = '0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    total_d      = total_q;
    avail_d      = avail_q;
    pos_d        = pos_q;
    prev_d       = prev_q;
    valid_d      = valid_q;
    failed_d     = failed_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    need_d       = need_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_entry_d  = res_entry_q;

    case (state_q)
      gtbs_pkg::S_DECODE: begin
        lo_d = '0;
        hi_d = total_q;
        if (op_q) begin
          if (!valid_q || total_q == '0) begin
            res_valid_d  = 1'b1;
            res_status_d = gtbs_pkg::STAT_NOT_LOADED;
            res_index_d  = '0;
            res_entry_d  = '0;
          end
        end else if (refused) begin
          res_valid_d  = 1'b1;
          res_status_d = gtbs_pkg::STAT_OVERFLOW;
          res_index_d  = '0;
          res_entry_d  = '0;
        end
      end
      gtbs_pkg::S_ORDER: begin
        // Codepoints must rise: prev < cp
        cmp_a  = {1'b0, prev_q};
        cmp_b  = {1'b0, item_q.codepoint};
        need_d = gtbs_pkg::NeedW'(ceil_bytes) * gtbs_pkg::NeedW'(item_q.height);
        if (pos_q != '0 && !cmp_flags.lt) begin
          failed_d     = 1'b1;
          res_valid_d  = 1'b1;
          res_status_d = gtbs_pkg::STAT_ORDER_ERR;
          res_index_d  = '0;
          res_entry_d  = '0;
        end
      end
      gtbs_pkg::S_RANGE: begin
        // Bitmap end must not pass the area size
        cmp_a       = {1'b0, avail_q};
        cmp_b       = {1'b0, item_q.bitmap_start} + gtbs_pkg::CmpW'(need_q);
        res_valid_d = 1'b1;
        res_index_d = '0;
        res_entry_d = '0;
        if (cmp_flags.lt) begin
          failed_d     = 1'b1;
          res_status_d = gtbs_pkg::STAT_RANGE_ERR;
        end else begin
          mem_we = 1'b1;
          pos_d  = pos_inc;
          prev_d = item_q.codepoint;
          if (pos_inc == total_q) begin
            valid_d      = 1'b1;
            res_status_d = gtbs_pkg::STAT_COMPLETE;
          end else begin
            res_status_d = gtbs_pkg::STAT_ACCEPTED;
          end
        end
      end
      gtbs_pkg::S_PROBE: begin
        if (lo_lt_hi) begin
          mem_re = 1'b1;
          mid_d  = mid_full[AddrW-1:0];
        end else begin
          res_valid_d  = 1'b1;
          res_status_d = gtbs_pkg::STAT_NOT_FOUND;
          res_index_d  = '0;
          res_entry_d  = '0;
        end
      end
      gtbs_pkg::S_COMPARE: begin
        cmp_a = {1'b0, mem_rdata.codepoint};
        cmp_b = {1'b0, item_q.codepoint};
        if (cmp_flags.eq) begin
          res_valid_d  = 1'b1;
          res_status_d = gtbs_pkg::STAT_FOUND;
          res_index_d  = gtbs_pkg::FoundIdxW'(mid_q);
          res_entry_d  = mem_rdata;
        end else if (cmp_flags.lt) begin
          lo_d = CntW'(mid_q) + CntW'(1);
        end else begin
          hi_d = CntW'(mid_q);
        end
      end
      default: begin
      end
    endcase

    // Apply configuration writes; restart loading on a new total
    if (cfg_write) begin
      case (gtbs_pkg::cfg_reg_e'(cfg_index_i))
        gtbs_pkg::REG_GLYPH_TOTAL: begin
          total_d  = total_req;
          pos_d    = '0;
          prev_d   = '0;
          valid_d  = 1'b0;
          failed_d = 1'b0;
        end
        gtbs_pkg::REG_BITMAP_BYTES: begin
          avail_d = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gtbs_pkg::S_IDLE;
      total_q     <= '0;
      avail_q     <= '0;
      pos_q       <= '0;
      prev_q      <= '0;
      valid_q     <= 1'b0;
      failed_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      avail_q     <= avail_d;
      pos_q       <= pos_d;
      prev_q      <= prev_d;
      valid_q     <= valid_d;
      failed_q    <= failed_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q                <= operation_i;
      item_q.codepoint    <= codepoint_i;
      item_q.width        <= glyph_width_i;
      item_q.height       <= glyph_height_i;
      item_q.offset_x     <= offset_x_i;
      item_q.offset_y     <= offset_y_i;
      item_q.advance      <= advance_width_i;
      item_q.bitmap_start <= bitmap_start_i;
    end
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    need_q       <= need_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_entry_q  <= res_entry_d;
  end

  // Drive result ports
  assign result_valid_o       = res_valid_q;
  assign status_o             = res_status_q;
  assign found_index_o        = res_index_q;
  assign found_width_o        = res_entry_q.width;
  assign found_height_o       = res_entry_q.height;
  assign found_offset_x_o     = res_entry_q.offset_x;
  assign found_offset_y_o     = res_entry_q.offset_y;
  assign found_advance_o      = res_entry_q.advance;
  assign found_bitmap_start_o = res_entry_q.bitmap_start;

  // Assertions
  a_strobe_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q != gtbs_pkg::S_IDLE))
    else $error("result strobe without a request in progress");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= total_q)
    else $error("load position beyond glyph total");

  a_valid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (pos_q == total_q) && !failed_q)
    else $error("table valid while not fully loaded");

  a_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_status_q != gtbs_pkg::STAT_FOUND) |->
      (res_entry_q == '0) && (res_index_q == '0))
    else $error("result fields set on a non-found result");

endmodule

>>> tb/sv/tb_glyph_table_binary_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_table_binary_search_unit
// Self-checking testbench of the glyph table loader and lookup unit.
// ----------------------------------------------------------------------------
// A short table of directed requests walks the reset state, refused loads,
// order and bitmap range failures, boundary fits and lookups in tiny tables.
// A full table of 1024 entries (written as an oversized total) then exercises
// every index bit, followed by many small tables built from mostly valid load
// sequences with random content, broken sequences and noise. An in-bench
// glyph table model predicts each result a directed row does not fix; results
// are checked field by field in order of issue. The sender pauses between random bursts.
// ----------------------------------------------------------------------------
module tb_glyph_table_binary_search_unit;

  localparam int unsigned MaxGlyphs  = 1024;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned ItemTarget = 1150;
  localparam logic        OpLoad     = 1'b0;
  localparam logic        OpLookup   = 1'b1;
  // Bitmap bytes of the widest and tallest glyph
  localparam logic [31:0] HugeBitmap = 32'd536862720;

  typedef struct packed {
    logic               op;
    logic [31:0]        cp;
    logic [15:0]        w;
    logic [15:0]        h;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [15:0]        adv;
    logic [31:0]        bstart;
  } glyph_req_t;

  typedef struct packed {
    gtbs_pkg::status_e  status;
    logic [9:0]         index;
    logic [15:0]        w;
    logic [15:0]        h;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [15:0]        adv;
    logic [31:0]        bstart;
  } glyph_resp_t;

  typedef struct {
    bit                is_cfg;
    bit                wr_total;
    logic [31:0]       total_data;
    bit                wr_bitmap;
    logic [31:0]       bitmap_data;
    glyph_req_t        rq;
    bit                typed;
    gtbs_pkg::status_e typed_st;
  } stim_row_t;

  // DUT signals
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [gtbs_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [gtbs_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          operation_i = 1'b0;
  logic [31:0]                   codepoint_i = '0;
  logic [15:0]                   glyph_width_i = '0;
  logic [15:0]                   glyph_height_i = '0;
  logic signed [15:0]            offset_x_i = '0;
  logic signed [15:0]            offset_y_i = '0;
  logic [15:0]                   advance_width_i = '0;
  logic [31:0]                   bitmap_start_i = '0;
  logic                          result_valid_o;
  logic [gtbs_pkg::StatusW-1:0]  status_o;
  logic [gtbs_pkg::FoundIdxW-1:0] found_index_o;
  logic [15:0]                   found_width_o;
  logic [15:0]                   found_height_o;
  logic signed [15:0]            found_offset_x_o;
  logic signed [15:0]            found_offset_y_o;
  logic [15:0]                   found_advance_o;
  logic [31:0]                   found_bitmap_start_o;

  // Glyph table model state
  gtbs_pkg::glyph_entry_t glyph_mem [MaxGlyphs];
  int unsigned  load_pos;
  logic [31:0]  prev_cp;
  bit           tbl_valid;
  bit           load_err;
  int unsigned  total_cfg;
  logic [31:0]  bitmap_cfg;

  // Bookkeeping
  glyph_resp_t  expected_results [$];
  stim_row_t    stim_rows [$];
  int unsigned  error_count;
  int unsigned  results_checked;
  int unsigned  load_count;
  int unsigned  lookup_count;
  int unsigned  hit_count;
  int unsigned  complete_count;
  int unsigned  cycle_count;
  int unsigned  burst_left;

  glyph_table_binary_search_unit #(
    .MAX_GLYPHS(MaxGlyphs)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .start               (start),
    .busy                (busy),
    .operation_i         (operation_i),
    .codepoint_i         (codepoint_i),
    .glyph_width_i       (glyph_width_i),
    .glyph_height_i      (glyph_height_i),
    .offset_x_i          (offset_x_i),
    .offset_y_i          (offset_y_i),
    .advance_width_i     (advance_width_i),
    .bitmap_start_i      (bitmap_start_i),
    .result_valid_o      (result_valid_o),
    .status_o            (status_o),
    .found_index_o       (found_index_o),
    .found_width_o       (found_width_o),
    .found_height_o      (found_height_o),
    .found_offset_x_o    (found_offset_x_o),
    .found_offset_y_o    (found_offset_y_o),
    .found_advance_o     (found_advance_o),
    .found_bitmap_start_o(found_bitmap_start_o)
  );

  // Free-running clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Apply a register write to the model; a total write restarts loading
  function automatic void apply_register_write(gtbs_pkg::cfg_reg_e idx, logic [31:0] data);
    case (idx)
      gtbs_pkg::REG_GLYPH_TOTAL: begin
        total_cfg = (int'(data[10:0]) > MaxGlyphs) ? MaxGlyphs : int'(data[10:0]);
        load_pos  = 0;
        prev_cp   = '0;
        tbl_valid = 1'b0;
        load_err  = 1'b0;
      end
      gtbs_pkg::REG_BITMAP_BYTES: begin
        bitmap_cfg = data;
      end
      default: ;
    endcase
  endfunction

  // Predict the result of one request and advance the model
  function automatic glyph_resp_t predict_glyph_result(glyph_req_t rq);
    glyph_resp_t rs;
    logic [63:0] need;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    bit          hit;
    rs  = '0;
    hit = 1'b0;
    if (rq.op == OpLoad) begin
      need = ((64'(rq.w) + 64'd7) / 64'd8) * 64'(rq.h);
      if (total_cfg == 0 || tbl_valid || load_err || load_pos >= total_cfg) begin
        rs.status = gtbs_pkg::STAT_OVERFLOW;
      end else if (load_pos > 0 && rq.cp <= prev_cp) begin
        load_err  = 1'b1;
        rs.status = gtbs_pkg::STAT_ORDER_ERR;
      end else if (64'(rq.bstart) + need > 64'(bitmap_cfg)) begin
        load_err  = 1'b1;
        rs.status = gtbs_pkg::STAT_RANGE_ERR;
      end else begin
        glyph_mem[load_pos] = '{codepoint: rq.cp, width: rq.w, height: rq.h,
                                offset_x: rq.ox, offset_y: rq.oy, advance: rq.adv,
                                bitmap_start: rq.bstart};
        load_pos++;
        prev_cp = rq.cp;
        if (load_pos == total_cfg) begin
          tbl_valid = 1'b1;
          rs.status = gtbs_pkg::STAT_COMPLETE;
        end else begin
          rs.status = gtbs_pkg::STAT_ACCEPTED;
        end
      end
    end else if (!tbl_valid || total_cfg == 0) begin
      rs.status = gtbs_pkg::STAT_NOT_LOADED;
    end else begin
      rs.status = gtbs_pkg::STAT_NOT_FOUND;
      lo = 0;
      hi = total_cfg;
      while (lo < hi && !hit) begin
        mid = lo + (hi - lo) / 2;
        if (glyph_mem[mid].codepoint == rq.cp) begin
          hit       = 1'b1;
          rs.status = gtbs_pkg::STAT_FOUND;
          rs.index  = mid[9:0];
          rs.w      = glyph_mem[mid].width;
          rs.h      = glyph_mem[mid].height;
          rs.ox     = glyph_mem[mid].offset_x;
          rs.oy     = glyph_mem[mid].offset_y;
          rs.adv    = glyph_mem[mid].advance;
          rs.bstart = glyph_mem[mid].bitmap_start;
        end else if (glyph_mem[mid].codepoint < rq.cp) begin
          lo = mid + 1;
        end else begin
          hi = mid;
        end
      end
    end
    return rs;
  endfunction

  // Directed table rows
  function automatic void add_request(logic op, logic [31:0] cp, logic [15:0] w,
                                      logic [15:0] h, logic signed [15:0] ox,
                                      logic signed [15:0] oy, logic [15:0] adv,
                                      logic [31:0] bs, bit typed, gtbs_pkg::status_e st);
    stim_row_t row;
    row.is_cfg      = 1'b0;
    row.wr_total    = 1'b0;
    row.total_data  = '0;
    row.wr_bitmap   = 1'b0;
    row.bitmap_data = '0;
    row.rq          = '{op: op, cp: cp, w: w, h: h, ox: ox, oy: oy, adv: adv, bstart: bs};
    row.typed       = typed;
    row.typed_st    = st;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_config(bit wr_total, logic [31:0] total_data,
                                     bit wr_bitmap, logic [31:0] bitmap_data);
    stim_row_t row;
    row.is_cfg      = 1'b1;
    row.wr_total    = wr_total;
    row.total_data  = total_data;
    row.wr_bitmap   = wr_bitmap;
    row.bitmap_data = bitmap_data;
    row.rq          = '0;
    row.typed       = 1'b0;
    row.typed_st    = gtbs_pkg::STAT_ACCEPTED;
    stim_rows.push_back(row);
  endfunction

  // Random request content
  function automatic glyph_req_t random_request(logic op, logic [31:0] cp);
    glyph_req_t rq;
    rq.op     = op;
    rq.cp     = cp;
    rq.w      = 16'($urandom);
    rq.h      = 16'($urandom);
    rq.ox     = 16'($urandom);
    rq.oy     = 16'($urandom);
    rq.adv    = 16'($urandom);
    rq.bstart = $urandom;
    return rq;
  endfunction

  // Random load whose bitmap fits the current bitmap area
  function automatic glyph_req_t fitting_load(logic [31:0] cp);
    glyph_req_t  rq;
    logic [63:0] need;
    rq = random_request(OpLoad, cp);
    if (bitmap_cfg < 32'h2000_0000) begin
      rq.w = 16'($urandom_range(0, 40));
      rq.h = 16'($urandom_range(0, 6));
    end
    need = ((64'(rq.w) + 64'd7) / 64'd8) * 64'(rq.h);
    if (need > 64'(bitmap_cfg)) begin
      rq.h = '0;
      need = '0;
    end
    rq.bstart = $urandom_range(0, bitmap_cfg - need[31:0]);
    return rq;
  endfunction

  // Flag one field mismatch
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Pause the sender between bursts of random length
  task automatic pace_sender();
    if (burst_left == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Issue one request, predict its result on acceptance
  task automatic issue_request(input glyph_req_t rq, input bit typed,
                               input gtbs_pkg::status_e typed_st,
                               output gtbs_pkg::status_e st);
    glyph_resp_t rs;
    start           <= 1'b1;
    operation_i     <= rq.op;
    codepoint_i     <= rq.cp;
    glyph_width_i   <= rq.w;
    glyph_height_i  <= rq.h;
    offset_x_i      <= rq.ox;
    offset_y_i      <= rq.oy;
    advance_width_i <= rq.adv;
    bitmap_start_i  <= rq.bstart;
    do @(posedge clk_i); while (busy);
    rs = predict_glyph_result(rq);
    if (typed) begin
      rs        = '0;
      rs.status = typed_st;
    end
    expected_results.push_back(rs);
    if (rq.op == OpLoad) load_count++;
    else lookup_count++;
    if (rs.status == gtbs_pkg::STAT_COMPLETE) complete_count++;
    st = rs.status;
    pace_sender();
  endtask

  // Drop start and wait until every outstanding result has arrived
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_register(gtbs_pkg::cfg_reg_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register_write(idx, data);
  endtask

  // Write the selected registers once the unit is idle
  task automatic configure_table(bit wr_total, logic [31:0] total_data,
                                 bit wr_bitmap, logic [31:0] bitmap_data);
    wait_idle();
    if (wr_bitmap) write_register(gtbs_pkg::REG_BITMAP_BYTES, bitmap_data);
    if (wr_total) write_register(gtbs_pkg::REG_GLYPH_TOTAL, total_data);
    cfg_valid_i <= 1'b0;
  endtask

  // Load a full table through an oversized total, then search it
  task automatic run_full_table();
    logic [31:0]       cps [MaxGlyphs];
    logic [31:0]       tmp;
    logic [31:0]       cp;
    gtbs_pkg::status_e st;
    int unsigned       k;
    tmp = $urandom;
    configure_table(1'b1, {tmp[31:11], 11'h7FF}, 1'b1, 32'hFFFF_FFFF);
    for (k = 0; k < MaxGlyphs; k++) begin
      cps[k] = 32'(k) * 32'd4000000 + $urandom_range(0, 3999999);
      issue_request(fitting_load(cps[k]), 1'b0, gtbs_pkg::STAT_FOUND, st);
    end
    // Refused load on a complete table
    issue_request(random_request(OpLoad, $urandom), 1'b0, gtbs_pkg::STAT_FOUND, st);
    issue_request(random_request(OpLookup, cps[0]), 1'b0, gtbs_pkg::STAT_FOUND, st);
    issue_request(random_request(OpLookup, cps[MaxGlyphs-1]), 1'b0, gtbs_pkg::STAT_FOUND, st);
    issue_request(random_request(OpLookup, 32'h0), 1'b0, gtbs_pkg::STAT_FOUND, st);
    issue_request(random_request(OpLookup, 32'hFFFF_FFFF), 1'b0, gtbs_pkg::STAT_FOUND, st);
    for (k = 0; k < 60; k++) begin
      case ($urandom_range(0, 3))
        0: cp = cps[$urandom_range(0, MaxGlyphs - 1)] + 32'd1;
        1: cp = $urandom;
        default: cp = cps[$urandom_range(0, MaxGlyphs - 1)];
      endcase
      issue_request(random_request(OpLookup, cp), 1'b0, gtbs_pkg::STAT_FOUND, st);
    end
  endtask

  // Build a small table from a mostly valid load sequence, then search it
  task automatic run_small_table();
    logic [31:0]       stored [$];
    logic [31:0]       tmp;
    logic [31:0]       cp;
    glyph_req_t        rq;
    gtbs_pkg::status_e st;
    int unsigned       n;
    int unsigned       k;
    int unsigned       loads;
    n   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
    tmp = $urandom;
    configure_table(1'b1, {tmp[31:11], 11'(n)}, $urandom_range(0, 4) != 0,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom);
    cp    = $urandom_range(0, 32'hFE00_0000);
    loads = n + $urandom_range(0, 2);
    for (k = 0; k < loads; k++) begin
      // Probe the table while it is still loading
      if ($urandom_range(0, 5) == 0) begin
        issue_request(random_request(OpLookup, $urandom), 1'b0, gtbs_pkg::STAT_FOUND, st);
      end
      rq = fitting_load(cp);
      // Break the sequence now and then
      if ($urandom_range(0, 11) == 0) begin
        if (stored.size() > 0 && $urandom_range(0, 1) == 1) begin
          rq.cp = stored[$] - $urandom_range(0, 3);
        end else begin
          rq.w      = 16'hFFFF;
          rq.h      = 16'hFFFF;
          rq.bstart = (bitmap_cfg >= HugeBitmap) ? bitmap_cfg - HugeBitmap + 32'd1 : $urandom;
        end
      end
      issue_request(rq, 1'b0, gtbs_pkg::STAT_FOUND, st);
      if (st == gtbs_pkg::STAT_ACCEPTED || st == gtbs_pkg::STAT_COMPLETE) begin
        stored.push_back(rq.cp);
      end
      cp = ((stored.size() > 0) ? stored[$] : cp) + $urandom_range(1, 32'h0010_0000);
    end
    for (k = $urandom_range(3, 12); k > 0; k--) begin
      tmp = $urandom_range(0, 9);
      if (stored.size() > 0 && tmp < 6) begin
        cp = stored[$urandom_range(0, stored.size() - 1)];
      end else if (stored.size() > 0 && tmp < 8) begin
        cp = stored[$urandom_range(0, stored.size() - 1)] + (tmp[0] ? 32'd1 : 32'hFFFF_FFFF);
      end else begin
        cp = $urandom;
      end
      issue_request(random_request(OpLookup, cp), 1'b0, gtbs_pkg::STAT_FOUND, st);
    end
  endtask

  // Compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    glyph_resp_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: status %0d with no request outstanding",
                 $time, status_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("found_index", 32'(want.index), 32'(found_index_o));
        check_field("found_width", 32'(want.w), 32'(found_width_o));
        check_field("found_height", 32'(want.h), 32'(found_height_o));
        check_field("found_offset_x", 32'(want.ox), 32'(found_offset_x_o));
        check_field("found_offset_y", 32'(want.oy), 32'(found_offset_y_o));
        check_field("found_advance", 32'(want.adv), 32'(found_advance_o));
        check_field("found_bitmap_start", want.bstart, found_bitmap_start_o);
        if (want.status == gtbs_pkg::STAT_FOUND) hit_count++;
        results_checked++;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    gtbs_pkg::status_e st;
    // Reset state: no table
    add_request(OpLookup, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1'b1,
                gtbs_pkg::STAT_NOT_LOADED);
    add_request(OpLoad, 32'h0, 1, 1, 0, 0, 0, 0, 1'b1, gtbs_pkg::STAT_OVERFLOW);
    // Exact bitmap fit, then an equal codepoint latches an order failure
    add_config(1'b1, 32'd3, 1'b1, 32'd100);
    add_request(OpLoad, 32'd5, 8, 4, -16'sd32768, 16'sd32767, 16'hFFFF, 32'd96,
                1'b1, gtbs_pkg::STAT_ACCEPTED);
    add_request(OpLoad, 32'd5, 0, 0, 0, 0, 0, 0, 1'b1, gtbs_pkg::STAT_ORDER_ERR);
    add_request(OpLoad, 32'd6, 0, 0, 0, 0, 0, 0, 1'b1, gtbs_pkg::STAT_OVERFLOW);
    add_request(OpLookup, 32'd5, 0, 0, 0, 0, 0, 0, 1'b1, gtbs_pkg::STAT_NOT_LOADED);
    // Extreme codepoints and bitmap geometry
    add_config(1'b1, 32'd2, 1'b1, 32'hFFFF_FFFF);
    add_request(OpLoad, 32'h0, 16'hFFFF, 16'hFFFF, 16'sd32767, -16'sd32768, 16'h0, 32'h0,
                1'b1, gtbs_pkg::STAT_ACCEPTED);
    add_request(OpLoad, 32'hFFFF_FFFF, 1, 1, 0, 0, 16'h1234, 32'hFFFF_FFFE,
                1'b1, gtbs_pkg::STAT_COMPLETE);
    add_request(OpLoad, 32'd1, 0, 0, 0, 0, 0, 0, 1'b1, gtbs_pkg::STAT_OVERFLOW);
    add_request(OpLookup, 32'h0, 0, 0, 0, 0, 0, 0, 1'b0, gtbs_pkg::STAT_FOUND);
    add_request(OpLookup, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1'b0, gtbs_pkg::STAT_FOUND);
    add_request(OpLookup, 32'd7, 0, 0, 0, 0, 0, 0, 1'b1, gtbs_pkg::STAT_NOT_FOUND);
    // Shrunk bitmap area leaves loaded entries alone
    add_config(1'b0, 32'd0, 1'b1, 32'd10);
    add_request(OpLookup, 32'h0, 0, 0, 0, 0, 0, 0, 1'b0, gtbs_pkg::STAT_FOUND);
    // Upper total bits are dropped: this writes a total of one
    add_config(1'b1, 32'hFFFF_F801, 1'b0, 32'd0);
    add_request(OpLoad, 32'd9, 8, 2, 0, 0, 0, 32'd9, 1'b1, gtbs_pkg::STAT_RANGE_ERR);
    add_config(1'b1, 32'd1, 1'b0, 32'd0);
    add_request(OpLoad, 32'd9, 9, 1, 16'sd3, -16'sd3, 16'd7, 32'd8,
                1'b1, gtbs_pkg::STAT_COMPLETE);
    add_request(OpLookup, 32'd8, 0, 0, 0, 0, 0, 0, 1'b1, gtbs_pkg::STAT_NOT_FOUND);
    add_request(OpLookup, 32'd10, 0, 0, 0, 0, 0, 0, 1'b1, gtbs_pkg::STAT_NOT_FOUND);
    add_request(OpLookup, 32'd9, 0, 0, 0, 0, 0, 0, 1'b0, gtbs_pkg::STAT_FOUND);
    // Bitmap end past 32 bits
    add_config(1'b1, 32'd4, 1'b1, 32'hFFFF_FFFF);
    add_request(OpLoad, 32'd1, 1, 1, 0, 0, 0, 32'hFFFF_FFFF, 1'b1, gtbs_pkg::STAT_RANGE_ERR);
    // Empty bitmap area with a zero-width glyph
    add_config(1'b1, 32'd1, 1'b1, 32'd0);
    add_request(OpLoad, 32'h8000_0000, 0, 16'hFFFF, 0, 0, 0, 32'h0,
                1'b1, gtbs_pkg::STAT_COMPLETE);
    add_request(OpLookup, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 1'b0, gtbs_pkg::STAT_FOUND);
    // Total of zero drops the table
    add_config(1'b1, 32'd0, 1'b0, 32'd0);
    add_request(OpLookup, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 1'b1,
                gtbs_pkg::STAT_NOT_LOADED);
    add_request(OpLoad, 32'd2, 0, 0, 0, 0, 0, 0, 1'b1, gtbs_pkg::STAT_OVERFLOW);

    apply_register_write(gtbs_pkg::REG_GLYPH_TOTAL, 32'd0);
    apply_register_write(gtbs_pkg::REG_BITMAP_BYTES, 32'd0);
    burst_left = 0;

    // Hold reset, then release it on a clock edge
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        configure_table(stim_rows[i].wr_total, stim_rows[i].total_data,
                        stim_rows[i].wr_bitmap, stim_rows[i].bitmap_data);
      end else begin
        issue_request(stim_rows[i].rq, stim_rows[i].typed, stim_rows[i].typed_st, st);
      end
    end

    run_full_table();
    while (load_count + lookup_count < ItemTarget) run_small_table();

    // Drain and watch for stray results
    wait_idle();
    repeat (30) @(posedge clk_i);

    $display("Covered %0d loads and %0d lookups; %0d results checked, %0d hits",
             load_count, lookup_count, results_checked, hit_count);
    $display("Tables completed: %0d, up to %0d entries; %0d mismatches",
             complete_count, MaxGlyphs, error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
